>>> src/rmq_pkg.sv
// Shared item codes and fixed port widths of the range minimum query engine.
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int KIND_W  = 2;
	localparam int IN_VAL_W = 32;
	localparam int POS_W   = 10;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
endpackage

>>> src/rmq_ram.sv
// Simple dual-port memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rmq_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/rmq_cmp.sv
// Shared compare unit: pick the position of the leftmost smaller value.
`timescale 1ns / 1ps
module rmq_cmp #(
	parameter int VW = 32,
	parameter int PW = 10
) (
	input  logic [VW-1:0] val_a,
	input  logic [VW-1:0] val_b,
	input  logic [PW-1:0] pos_a,
	input  logic [PW-1:0] pos_b,
	output logic [PW-1:0] pick
);
	// a is the left candidate, so it wins ties
	assign pick = (val_b < val_a) ? pos_b : pos_a;
endmodule

>>> src/range_minimum_query_engine_unit.sv
// Top level of the range minimum query engine: sequencer, stores and result register.
`timescale 1ns / 1ps
// Values are appended one at a time; each append writes the value and then
// extends a sparse table of argmin positions, one level at a time, through
// one shared compare unit. Entry (k, i) holds the leftmost minimum position
// of the 2^k values starting at i. A query compares two overlapping windows
// of the same level. Clear and unused kinds give no result. A full append
// or an out-of-range query gives its error result the cycle after start.
// A query runs through the states RD_A, RD_B, RD_VA and CMP (two table
// reads and two value reads through the single read port of each memory,
// then a compare). An append of the value at position p writes the value
// and level zero, then builds floor(log2(p+1)) more levels through the
// same states. busy is high while an item is in work. The result is on
// min_position/error for exactly one cycle while done is high; the receiver
// cannot stall it, so take it then. No clearing pass: stale entries are
// never read, since only windows below the loaded count are looked at.
module range_minimum_query_engine_unit #(
	parameter int MAX_VALUES  = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rmq_pkg::KIND_W-1:0]  kind,
	input  logic [rmq_pkg::IN_VAL_W-1:0] value,
	input  logic [rmq_pkg::POS_W-1:0]   left_pos,
	input  logic [rmq_pkg::POS_W-1:0]   right_pos,
	output logic                      done,
	output logic [rmq_pkg::POS_W-1:0]   min_position,
	output logic                      error
);
	localparam int PW     = $clog2(MAX_VALUES);
	localparam int CW     = $clog2(MAX_VALUES + 1);
	localparam int LEVELS = $clog2(MAX_VALUES + 1) - (((MAX_VALUES + 1) & MAX_VALUES) != 0 ? 0 : 0)
		- ((2 ** ($clog2(MAX_VALUES + 1) - 1)) > MAX_VALUES ? 1 : 0);
	localparam int KW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int TW     = KW + PW;
	localparam int QW     = (CW > rmq_pkg::POS_W) ? CW : rmq_pkg::POS_W;
	localparam int VX     = (VALUE_WIDTH > rmq_pkg::IN_VAL_W) ? VALUE_WIDTH : rmq_pkg::IN_VAL_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD_A  = 3'd1;
	localparam logic [2:0] ST_RD_B  = 3'd2;
	localparam logic [2:0] ST_RD_VA = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic          query_q;
	logic [KW-1:0] lvl_q;      // level being read
	logic [PW-1:0] ia_q, ib_q;
	logic [CW:0]   span_q;     // window size of the level being written
	logic [PW-1:0] pa_q;
	logic [VALUE_WIDTH-1:0] va_q;
	logic          done_q, err_q;
	logic [rmq_pkg::POS_W-1:0] pos_q;

	logic accept;
	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// query decode: order the positions, check range, pick the level
	logic [QW-1:0] l_ext, r_ext, lo, hi;
	logic          q_bad;
	logic [PW:0]   q_len;
	logic [KW-1:0] q_lvl;
	logic [PW:0]   q_b;
	always_comb begin
		l_ext = QW'(left_pos);
		r_ext = QW'(right_pos);
		lo = (l_ext > r_ext) ? r_ext : l_ext;
		hi = (l_ext > r_ext) ? l_ext : r_ext;
		q_bad = (hi >= QW'(count_q));
		q_len = (PW + 1)'(hi[PW-1:0]) - (PW + 1)'(lo[PW-1:0]) + (PW + 1)'(1);
		q_lvl = '0;
		for (int j = 0; j <= PW; j++) begin
			if (q_len[j]) begin
				q_lvl = KW'(j);
			end
		end
		q_b = (PW + 1)'(hi[PW-1:0]) + (PW + 1)'(1) - ((PW + 1)'(1) << q_lvl);
	end

	logic [VX-1:0] v_ext;
	assign v_ext = VX'(value);

	// memories
	logic          tab_we;
	logic [TW-1:0] tab_waddr, tab_raddr;
	logic [PW-1:0] tab_wdata, tab_rdata;
	logic [PW-1:0] val_raddr;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic          val_we;
	logic [PW-1:0] pick;

	rmq_ram #(.DEPTH(MAX_VALUES), .AW(PW), .DW(VALUE_WIDTH)) u_val (
		.clk(clk), .we(val_we), .waddr(count_q[PW-1:0]),
		.wdata(v_ext[VALUE_WIDTH-1:0]), .raddr(val_raddr), .rdata(val_rdata)
	);

	rmq_ram #(.DEPTH(LEVELS * (2 ** PW)), .AW(TW), .DW(PW)) u_tab (
		.clk(clk), .we(tab_we), .waddr(tab_waddr),
		.wdata(tab_wdata), .raddr(tab_raddr), .rdata(tab_rdata)
	);

	rmq_cmp #(.VW(VALUE_WIDTH), .PW(PW)) u_cmp (
		.val_a(va_q), .val_b(val_rdata), .pos_a(pa_q), .pos_b(tab_rdata), .pick(pick)
	);

	logic app_ok;
	assign app_ok = accept && (kind == rmq_pkg::KIND_APPEND) && (count_q != CW'(MAX_VALUES));
	assign val_we = app_ok;

	// level zero of the new position is the position itself
	always_comb begin
		tab_we    = 1'b0;
		tab_waddr = {KW'(0), count_q[PW-1:0]};
		tab_wdata = count_q[PW-1:0];
		if (app_ok) begin
			tab_we = 1'b1;
		end else if (state_q == ST_CMP && !query_q) begin
			tab_we    = 1'b1;
			tab_waddr = {lvl_q + KW'(1), ia_q};
			tab_wdata = pick;
		end
	end

	assign tab_raddr = (state_q == ST_RD_A) ? {lvl_q, ia_q} : {lvl_q, ib_q};
	assign val_raddr = (state_q == ST_RD_B) ? tab_rdata : tab_rdata;

	// next level of an append
	logic [CW:0] nspan;
	logic        more;
	always_comb begin
		nspan = span_q << 1;
		more  = ((KW + 1)'(lvl_q) + (KW + 1)'(2) < (KW + 1)'(LEVELS))
			&& (nspan <= (CW + 1)'(count_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							rmq_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							rmq_pkg::KIND_APPEND: begin
								if (!app_ok) begin
									done_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
									if (count_q != '0) begin
										state_q <= ST_RD_A;
									end
								end
							end
							rmq_pkg::KIND_QUERY: begin
								if (q_bad) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_RD_A;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD_A:  state_q <= ST_RD_B;
				ST_RD_B:  state_q <= ST_RD_VA;
				ST_RD_VA: state_q <= ST_CMP;
				ST_CMP: begin
					if (query_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (more) begin
						state_q <= ST_RD_A;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	logic [QW-1:0] pick_ext;
	assign pick_ext = QW'(pick);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q <= 1'b1;
				pos_q <= '0;
				if (kind == rmq_pkg::KIND_QUERY) begin
					query_q <= 1'b1;
					lvl_q   <= q_lvl;
					ia_q    <= lo[PW-1:0];
					ib_q    <= q_b[PW-1:0];
				end else begin
					query_q <= 1'b0;
					lvl_q   <= '0;
					ia_q    <= PW'(count_q - CW'(1));
					ib_q    <= count_q[PW-1:0];
					span_q  <= (CW + 1)'(2);
				end
			end
			ST_RD_B: begin
				pa_q <= tab_rdata;
			end
			ST_RD_VA: begin
				va_q <= val_rdata;
			end
			ST_CMP: begin
				err_q  <= 1'b0;
				pos_q  <= pick_ext[rmq_pkg::POS_W-1:0];
				lvl_q  <= lvl_q + KW'(1);
				span_q <= nspan;
				ia_q   <= PW'((CW + 1)'(count_q) - nspan);
				ib_q   <= PW'((CW + 1)'(count_q) - nspan + span_q);
			end
			default: begin
			end
		endcase
	end

	assign done         = done_q;
	assign min_position = pos_q;
	assign error        = err_q;
endmodule

>>> test/tb_range_minimum_query_engine_unit.sv
// Testbench for the range minimum query engine: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb_range_minimum_query_engine_unit;
	localparam int STORE_DEPTH = 1024;
	localparam int LARGE_LOAD  = 250;
	localparam logic [rmq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [rmq_pkg::POS_W-1:0] pos;
		logic                      err;
	} answer_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [rmq_pkg::KIND_W-1:0]   kind;
	logic [rmq_pkg::IN_VAL_W-1:0] value;
	logic [rmq_pkg::POS_W-1:0]    left_pos;
	logic [rmq_pkg::POS_W-1:0]    right_pos;
	logic                         done;
	logic [rmq_pkg::POS_W-1:0]    min_position;
	logic                         error;

	// Predictor state: the loaded values and how many there are.
	logic [rmq_pkg::IN_VAL_W-1:0] loaded_values [STORE_DEPTH];
	int                           loaded_count;
	answer_t                      pending_answers [$];
	int                           fail_count;
	int                           idle_pct;

	range_minimum_query_engine_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .value(value), .left_pos(left_pos), .right_pos(right_pos),
		.done(done), .min_position(min_position), .error(error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

	// Leftmost minimum by a plain scan; the block's tables must agree with it.
	function automatic logic [rmq_pkg::POS_W-1:0] leftmost_min(int lo, int hi);
		int best;
		best = lo;
		for (int i = lo + 1; i <= hi; i++)
			if (loaded_values[i] < loaded_values[best])
				best = i;
		return best[rmq_pkg::POS_W-1:0];
	endfunction

	// Add one expected result at the tail of the queue.
	task automatic queue_answer(logic [rmq_pkg::POS_W-1:0] p, logic e);
		answer_t a;
		a.pos = p;
		a.err = e;
		pending_answers = {pending_answers, a};
	endtask

	// Advance the predictor by one accepted item, queueing any result it causes.
	task automatic predict_item(logic [rmq_pkg::KIND_W-1:0] k,
			logic [rmq_pkg::IN_VAL_W-1:0] v,
			logic [rmq_pkg::POS_W-1:0] a, logic [rmq_pkg::POS_W-1:0] b);
		int lo;
		int hi;
		lo = (a < b) ? int'(a) : int'(b);
		hi = (a < b) ? int'(b) : int'(a);
		case (k)
			rmq_pkg::KIND_CLEAR: begin
				loaded_count = 0;
			end
			rmq_pkg::KIND_APPEND: begin
				if (loaded_count >= STORE_DEPTH) begin
					queue_answer('0, 1'b1);
				end else begin
					loaded_values[loaded_count] = v;
					loaded_count++;
				end
			end
			rmq_pkg::KIND_QUERY: begin
				if (hi >= loaded_count)
					queue_answer('0, 1'b1);
				else
					queue_answer(leftmost_min(lo, hi), 1'b0);
			end
			default: ;
		endcase
	endtask

	// Drive one item at the falling edge, hold until the block takes it.
	task automatic send_item(logic [rmq_pkg::KIND_W-1:0] k,
			logic [rmq_pkg::IN_VAL_W-1:0] v,
			logic [rmq_pkg::POS_W-1:0] a, logic [rmq_pkg::POS_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start     = 1'b1;
		kind      = k;
		value     = v;
		left_pos  = a;
		right_pos = b;
		do @(posedge clk); while (busy);
		predict_item(k, v, a, b);
	endtask

	// Drop start and hold until every queued result has come back.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// Check each result strobe against the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result: min_position %0d error %0b", min_position, error);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (error !== want.err) begin
					$error("error: expected %0b actual %0b", want.err, error);
					fail_count++;
				end
				if (min_position !== want.pos) begin
					$error("min_position: expected %0d actual %0d", want.pos, min_position);
					fail_count++;
				end
			end
		end
	end

	// Empty store, extremes of values and positions, ties, swapped and unused kinds.
	task automatic test_directed();
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_APPEND, 32'hFFFF_FFFF, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_APPEND, 32'd7, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_APPEND, 32'd0, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_APPEND, 32'd0, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_APPEND, 32'hFFFF_FFFF, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_QUERY, 32'hFFFF_FFFF, 10'd4, 10'd0);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, 10'd1);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd3, 10'd2);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd3, 10'd3);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, 10'd5);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'h3FF, 10'h3FF);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd1, 10'd2);
		send_item(rmq_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_APPEND, 32'd5, 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, 10'd0);
	endtask

	// Load a long set so that deep table levels are built, then query wide spans.
	task automatic test_large_store();
		send_item(rmq_pkg::KIND_CLEAR, 32'd0, 10'd0, 10'd0);
		for (int i = 0; i < LARGE_LOAD; i++)
			send_item(rmq_pkg::KIND_APPEND, 32'($urandom_range(1, 50)), 10'd0, 10'd0);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, 10'd0, rmq_pkg::POS_W'(LARGE_LOAD - 1));
		send_item(rmq_pkg::KIND_QUERY, 32'd0, rmq_pkg::POS_W'(LARGE_LOAD - 1), 10'd0);
		send_item(rmq_pkg::KIND_QUERY, 32'd0, rmq_pkg::POS_W'(LARGE_LOAD - 1),
			rmq_pkg::POS_W'(LARGE_LOAD - 1));
		send_item(rmq_pkg::KIND_QUERY, 32'd0, rmq_pkg::POS_W'(LARGE_LOAD),
			rmq_pkg::POS_W'(LARGE_LOAD / 2));
		send_item(rmq_pkg::KIND_QUERY, 32'd0, rmq_pkg::POS_W'(LARGE_LOAD / 2),
			rmq_pkg::POS_W'(LARGE_LOAD / 2 - 1));
		for (int i = 0; i < 12; i++)
			send_item(rmq_pkg::KIND_QUERY, 32'd0,
				rmq_pkg::POS_W'($urandom_range(0, LARGE_LOAD - 1)),
				rmq_pkg::POS_W'($urandom_range(0, LARGE_LOAD - 1)));
	endtask

	// Mostly well-formed sets: clear, a short load, then queries with some noise.
	task automatic test_random(int items);
		int sent;
		int set_size;
		logic [rmq_pkg::IN_VAL_W-1:0] v;
		sent = 0;
		while (sent < items) begin
			send_item(rmq_pkg::KIND_CLEAR, $urandom, rmq_pkg::POS_W'($urandom),
				rmq_pkg::POS_W'($urandom));
			set_size = $urandom_range(1, 40);
			for (int i = 0; i < set_size; i++) begin
				v = ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(0, 3));
				send_item(rmq_pkg::KIND_APPEND, v, rmq_pkg::POS_W'($urandom),
					rmq_pkg::POS_W'($urandom));
			end
			sent += set_size + 1;
			for (int i = 0; i < 8; i++) begin
				case ($urandom_range(9))
					0: send_item(rmq_pkg::KIND_QUERY, $urandom, rmq_pkg::POS_W'($urandom),
						rmq_pkg::POS_W'($urandom));
					1: send_item(KIND_UNUSED, $urandom, rmq_pkg::POS_W'($urandom),
						rmq_pkg::POS_W'($urandom));
					2: send_item(rmq_pkg::KIND_APPEND, $urandom, rmq_pkg::POS_W'($urandom),
						rmq_pkg::POS_W'($urandom));
					default: send_item(rmq_pkg::KIND_QUERY, $urandom,
						rmq_pkg::POS_W'($urandom_range(0, loaded_count)),
						rmq_pkg::POS_W'($urandom_range(0, loaded_count - 1)));
				endcase
			end
			sent += 8;
		end
	endtask

	initial begin
		fail_count   = 0;
		loaded_count = 0;
		idle_pct     = 0;
		start        = 1'b0;
		kind         = rmq_pkg::KIND_CLEAR;
		value        = '0;
		left_pos     = '0;
		right_pos    = '0;
		arst_n       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		wait_idle();
		test_large_store();
		wait_idle();
		test_random(55);
		idle_pct = 59;
		test_random(55);
		wait_idle();
		idle_pct = 36;
		test_random(55);
		idle_pct = 0;
		test_random(55);
		wait_idle();

		if (fail_count == 0 && pending_answers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

>>> range_minimum_query_engine_unit.f
src/rmq_pkg.sv
src/rmq_ram.sv
src/rmq_cmp.sv
src/range_minimum_query_engine_unit.sv
test/tb_range_minimum_query_engine_unit.sv
